// ===== rtl/nmc_pkg.sv =====
// ----------------------------------------------------------------------------
// nmc_pkg
// Shared types and constants for the ICMPv6 neighbor discovery and MLDv2
// report classifier.
// ----------------------------------------------------------------------------
package nmc_pkg;

  localparam int unsigned PosWidth  = 16;
  localparam int unsigned SkipWidth = 21;
  localparam int unsigned OffWidth  = 5;

  localparam logic [7:0] TYPE_RS   = 8'd133;
  localparam logic [7:0] TYPE_NS   = 8'd135;
  localparam logic [7:0] TYPE_NA   = 8'd136;
  localparam logic [7:0] TYPE_MLD2 = 8'd143;

  localparam logic [7:0] KIND_CHANGE_TO_EXCLUDE = 8'd4;

  localparam logic [PosWidth-1:0] POS_COUNT_HI  = 16'd6;
  localparam logic [PosWidth-1:0] POS_COUNT_LO  = 16'd7;
  localparam logic [PosWidth-1:0] TARGET_FIRST  = 16'd8;
  localparam logic [PosWidth-1:0] TARGET_LAST   = 16'd23;

  localparam logic [OffWidth-1:0] OFF_KIND      = 5'd0;
  localparam logic [OffWidth-1:0] OFF_AUX       = 5'd1;
  localparam logic [OffWidth-1:0] OFF_SRC_HI    = 5'd2;
  localparam logic [OffWidth-1:0] OFF_SRC_LO    = 5'd3;
  localparam logic [OffWidth-1:0] OFF_GROUP     = 5'd4;
  localparam logic [OffWidth-1:0] OFF_PREFIX_END = 5'd17;
  localparam logic [OffWidth-1:0] OFF_HDR_LAST  = 5'd19;
  localparam logic [OffWidth-1:0] SKIP_PHASE    = 5'd20;

  localparam logic [7:0] TARGET_MASK  = 8'hE0;
  localparam logic [7:0] TARGET_MATCH = 8'h20;

  typedef enum logic [1:0] {
    ActRaReply = 2'd0,
    ActJoin    = 2'd1,
    ActProxy   = 2'd2
  } action_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
    logic       src_unspecified;
  } item_t;

  typedef struct packed {
    action_e     action;
    logic [63:0] addr_high;
    logic [63:0] addr_low;
  } result_t;

  // Solicited-node multicast prefix ff02::1:ff00:0/104, one byte per index.
  function automatic logic [7:0] snm_byte(input logic [3:0] idx);
    logic [7:0] val;
    case (idx)
      4'd0:    val = 8'hff;
      4'd1:    val = 8'h02;
      4'd11:   val = 8'h01;
      4'd12:   val = 8'hff;
      default: val = 8'h00;
    endcase
    return val;
  endfunction

endpackage

// ===== rtl/nmc_in_reg.sv =====
// ----------------------------------------------------------------------------
// nmc_in_reg
// Input register holding one message byte until the parser consumes it.
// ----------------------------------------------------------------------------
module nmc_in_reg (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  nmc_pkg::item_t item_i,
  input  logic           adv_ok_i,
  output logic           fire_o,
  output nmc_pkg::item_t item_o
);
  import nmc_pkg::*;

  logic  valid_q, valid_d;
  item_t item_q;
  logic  accept;

  assign fire_o     = valid_q && adv_ok_i;
  assign in_stall_o = valid_q && !adv_ok_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign item_o     = item_q;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (fire_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_i;
    end
  end

endmodule

// ===== rtl/nmc_parser.sv =====
// ----------------------------------------------------------------------------
// nmc_parser
// Per-byte message state and classification of router solicits, neighbor
// messages and MLDv2 group records.
// ----------------------------------------------------------------------------
module nmc_parser #(
  parameter int unsigned MAX_BYTES = 2048
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_wdata_i,
  input  logic             fire_i,
  input  nmc_pkg::item_t   item_i,
  output logic             res_valid_o,
  output nmc_pkg::result_t res_o
);
  import nmc_pkg::*;

  logic                 ra_ready_q;
  logic [PosWidth-1:0]  pos_q, pos_d;
  logic [7:0]           type_q, type_d;
  logic [15:0]          total_q, total_d;
  logic [15:0]          idx_q, idx_d;
  logic [OffWidth-1:0]  off_q, off_d;
  logic [7:0]           kind_q, kind_d;
  logic [SkipWidth-1:0] skip_q, skip_d;
  logic                 pm_q, pm_d;
  logic [63:0]          hi_q, hi_d;
  logic [63:0]          lo_q, lo_d;

  logic [7:0]           b;
  logic                 pos_ok;
  logic [SkipWidth-1:0] skip_dec;
  logic [3:0]           snm_idx;

  assign b        = item_i.data_byte;
  assign pos_ok   = pos_q < PosWidth'(MAX_BYTES);
  assign skip_dec = skip_q - SkipWidth'(1);
  assign snm_idx  = 4'(off_q - OFF_GROUP);

  always_comb begin
    pos_d       = pos_q;
    type_d      = type_q;
    total_d     = total_q;
    idx_d       = idx_q;
    off_d       = off_q;
    kind_d      = kind_q;
    skip_d      = skip_q;
    pm_d        = pm_q;
    hi_d        = hi_q;
    lo_d        = lo_q;
    res_valid_o = 1'b0;
    res_o       = '{action: ActRaReply, addr_high: 64'd0, addr_low: 64'd0};

    if (fire_i) begin
      if (pos_ok) begin
        if (pos_q == '0) begin
          type_d = b;
          if (b == TYPE_RS && ra_ready_q) begin
            res_valid_o = 1'b1;
          end
        end else if (type_q == TYPE_MLD2) begin
          if (pos_q == POS_COUNT_HI) begin
            total_d = {b, 8'h00};
          end else if (pos_q == POS_COUNT_LO) begin
            total_d = total_q | {8'h00, b};
          end else if (pos_q >= TARGET_FIRST && idx_q < total_q) begin
            if (off_q >= SKIP_PHASE) begin
              skip_d = skip_dec;
              if (skip_dec == '0) begin
                off_d = '0;
                idx_d = idx_q + 16'd1;
              end
            end else begin
              case (off_q)
                OFF_KIND: begin
                  kind_d = b;
                  skip_d = '0;
                end
                OFF_AUX: begin
                  skip_d = {11'd0, b, 2'd0};
                end
                OFF_SRC_HI: begin
                  skip_d = skip_q + {1'b0, b, 12'd0};
                end
                OFF_SRC_LO: begin
                  skip_d = skip_q + {9'd0, b, 4'd0};
                end
                default: begin
                  hi_d = {hi_q[55:0], lo_q[63:56]};
                  lo_d = {lo_q[55:0], b};
                  if (off_q == OFF_GROUP) begin
                    pm_d = (b == snm_byte(4'd0));
                  end else if (off_q < OFF_PREFIX_END) begin
                    pm_d = pm_q && (b == snm_byte(snm_idx));
                  end
                end
              endcase
              if (off_q == OFF_HDR_LAST) begin
                if (kind_d == KIND_CHANGE_TO_EXCLUDE && pm_d) begin
                  res_valid_o = 1'b1;
                  res_o       = '{action: ActJoin, addr_high: hi_d, addr_low: lo_d};
                end
                if (skip_d == '0) begin
                  off_d = '0;
                  idx_d = idx_q + 16'd1;
                end else begin
                  off_d = SKIP_PHASE;
                end
              end else begin
                off_d = off_q + OffWidth'(1);
              end
            end
          end
        end else if (type_q == TYPE_NS || type_q == TYPE_NA) begin
          if (pos_q >= TARGET_FIRST && pos_q <= TARGET_LAST) begin
            hi_d = {hi_q[55:0], lo_q[63:56]};
            lo_d = {lo_q[55:0], b};
            if (pos_q == TARGET_FIRST) begin
              pm_d = ((b & TARGET_MASK) == TARGET_MATCH);
            end
            if (pos_q == TARGET_LAST && pm_q &&
                (type_q == TYPE_NS || item_i.src_unspecified)) begin
              res_valid_o = 1'b1;
              res_o       = '{action: ActProxy, addr_high: hi_d, addr_low: lo_d};
            end
          end
        end
        pos_d = pos_q + PosWidth'(1);
      end

      if (item_i.last_byte) begin
        pos_d   = '0;
        type_d  = '0;
        total_d = '0;
        idx_d   = '0;
        off_d   = '0;
        kind_d  = '0;
        skip_d  = '0;
        pm_d    = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ra_ready_q <= 1'b0;
      pos_q      <= '0;
      type_q     <= '0;
      total_q    <= '0;
      idx_q      <= '0;
      off_q      <= '0;
      kind_q     <= '0;
      skip_q     <= '0;
      pm_q       <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        ra_ready_q <= cfg_wdata_i;
      end
      pos_q   <= pos_d;
      type_q  <= type_d;
      total_q <= total_d;
      idx_q   <= idx_d;
      off_q   <= off_d;
      kind_q  <= kind_d;
      skip_q  <= skip_d;
      pm_q    <= pm_d;
    end
  end

  // The address shift line is fully refilled before any result uses it.
  always_ff @(posedge clk_i) begin
    hi_q <= hi_d;
    lo_q <= lo_d;
  end

endmodule

// ===== rtl/nmc_out_reg.sv =====
// ----------------------------------------------------------------------------
// nmc_out_reg
// Result register presenting one action request to the downstream side.
// ----------------------------------------------------------------------------
module nmc_out_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  nmc_pkg::result_t res_i,
  output logic             adv_ok_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output nmc_pkg::result_t res_o
);
  import nmc_pkg::*;

  logic    valid_q, valid_d;
  result_t res_q;

  assign adv_ok_o    = !valid_q || !out_stall_i;
  assign out_valid_o = valid_q;
  assign res_o       = res_q;

  always_comb begin
    valid_d = valid_q && out_stall_i;
    if (load_i) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

endmodule

// ===== rtl/icmpv6_nd_mld_classifier_unit.sv =====
// ----------------------------------------------------------------------------
// icmpv6_nd_mld_classifier_unit
// Byte-wide ICMPv6 classifier raising RA reply, group join and neighbor
// proxy requests.
// ----------------------------------------------------------------------------
// Path: input register, combinational parser step, output register.
// Throughput: one byte per cycle while no result is stalled downstream.
// A byte is held back only while a finished result is stalled downstream.
// Reset is asynchronous and active low; it clears ra_ready and the message
// state but not the address shift line; bytes are accepted right after reset.
module icmpv6_nd_mld_classifier_unit #(
  parameter int unsigned MAX_BYTES = 2048
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  input  logic        src_unspecified_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  action_o,
  output logic [63:0] addr_high_o,
  output logic [63:0] addr_low_o
);
  import nmc_pkg::*;

  item_t   item_in, item_q;
  result_t res_comb, res_q;
  logic    adv_ok, fire, res_valid;

  assign item_in = '{data_byte: data_byte_i, last_byte: last_byte_i,
                     src_unspecified: src_unspecified_i};

  nmc_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .item_i     (item_in),
    .adv_ok_i   (adv_ok),
    .fire_o     (fire),
    .item_o     (item_q)
  );

  nmc_parser #(
    .MAX_BYTES (MAX_BYTES)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .fire_i      (fire),
    .item_i      (item_q),
    .res_valid_o (res_valid),
    .res_o       (res_comb)
  );

  nmc_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (res_valid),
    .res_i       (res_comb),
    .adv_ok_o    (adv_ok),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res_q)
  );

  assign action_o    = res_q.action;
  assign addr_high_o = res_q.addr_high;
  assign addr_low_o  = res_q.addr_low;

endmodule

// ===== rtl/nmc_checker.sv =====
// ----------------------------------------------------------------------------
// nmc_checker
// Port-level assertions for the classifier, bound to the top level.
// ----------------------------------------------------------------------------
module nmc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [1:0]  action_o,
  input logic [63:0] addr_high_o,
  input logic [63:0] addr_low_o
);
  import nmc_pkg::*;

  // A stalled request stays up with the same contents.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(action_o) &&
    $stable(addr_high_o) && $stable(addr_low_o))
    else $error("stalled request changed");

  a_action_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (action_o == ActRaReply || action_o == ActJoin ||
    action_o == ActProxy))
    else $error("undefined action code");

  a_ra_no_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && action_o == ActRaReply |-> addr_high_o == 64'd0 &&
    addr_low_o == 64'd0)
    else $error("RA reply carries an address");

  a_join_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && action_o == ActJoin |-> addr_high_o[63:48] == 16'hff02 &&
    addr_low_o[63:24] == 40'h00000001ff)
    else $error("join group outside solicited-node range");

  a_proxy_global: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && action_o == ActProxy |-> addr_high_o[63:61] == 3'b001)
    else $error("proxy target is not global unicast");

endmodule

bind icmpv6_nd_mld_classifier_unit nmc_checker u_nmc_checker (.*);
